/* rtl/sbe_pkg.sv */
// Shared types and constants of the stack bytecode executor.
// No dependencies; imported by the divider, the ALU and the top level.
package sbe_pkg;

    localparam logic [5:0] OP_END   = 6'd0;
    localparam logic [5:0] OP_PRS   = 6'd1;
    localparam logic [5:0] OP_PRV   = 6'd2;
    localparam logic [5:0] OP_PRNL  = 6'd3;
    localparam logic [5:0] OP_PRTAB = 6'd4;
    localparam logic [5:0] OP_STR   = 6'd5;
    localparam logic [5:0] OP_NUM   = 6'd6;
    localparam logic [5:0] OP_BNUM  = 6'd7;
    localparam logic [5:0] OP_LDV   = 6'd8;
    localparam logic [5:0] OP_STV   = 6'd9;
    localparam logic [5:0] OP_ADD   = 6'd10;
    localparam logic [5:0] OP_SUB   = 6'd11;
    localparam logic [5:0] OP_MUL   = 6'd12;
    localparam logic [5:0] OP_DIV   = 6'd13;
    localparam logic [5:0] OP_MOD   = 6'd14;
    localparam logic [5:0] OP_AND   = 6'd15;
    localparam logic [5:0] OP_OR    = 6'd16;
    localparam logic [5:0] OP_NOT   = 6'd17;
    localparam logic [5:0] OP_EQ    = 6'd18;
    localparam logic [5:0] OP_NE    = 6'd19;
    localparam logic [5:0] OP_LT    = 6'd20;
    localparam logic [5:0] OP_LE    = 6'd21;
    localparam logic [5:0] OP_GT    = 6'd22;
    localparam logic [5:0] OP_GE    = 6'd23;
    localparam logic [5:0] OP_GOTO  = 6'd24;
    localparam logic [5:0] OP_GOSUB = 6'd25;
    localparam logic [5:0] OP_RET   = 6'd26;
    localparam logic [5:0] OP_NEXT  = 6'd27;
    localparam logic [5:0] OP_IF    = 6'd28;
    localparam logic [5:0] OP_FUNC  = 6'd29;
    localparam logic [5:0] OP_PUT1  = 6'd30;
    localparam logic [5:0] OP_GET1  = 6'd31;
    localparam logic [5:0] OP_PUT2  = 6'd32;
    localparam logic [5:0] OP_GET2  = 6'd33;
    localparam logic [5:0] OP_PUT4  = 6'd34;
    localparam logic [5:0] OP_GET4  = 6'd35;
    localparam logic [5:0] OP_START = 6'd36;
    localparam logic [5:0] OP_HOSTW = 6'd37;

    localparam logic [2:0] PK_NONE  = 3'd0;
    localparam logic [2:0] PK_VALUE = 3'd1;
    localparam logic [2:0] PK_STR   = 3'd2;
    localparam logic [2:0] PK_NL    = 3'd3;
    localparam logic [2:0] PK_TAB   = 3'd4;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_FUNC = 2'd2;

    localparam logic [7:0]  FN_PEEK   = 8'd0;
    localparam logic [15:0] START_PC  = 16'd2;
    localparam logic [15:0] PLEN_RST  = 16'hFFFF;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_LAND, ALU_LOR, ALU_LNOT, ALU_EQ,
        ALU_NE, ALU_LT, ALU_LE, ALU_GT, ALU_GE, ALU_DBL
    } t_alu_op;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

/* rtl/sbe_if.sv */
// Valid/ready channel interfaces for instruction and result beats.
// Depends on nothing; used by the top level.
interface sbe_cmd_if;
    logic        valid;
    logic        ready;
    logic [5:0]  opcode;
    logic [31:0] immediate;
    logic [7:0]  var_index;
    logic [15:0] jump_target;
    logic [7:0]  func_code;
    modport source (output valid, opcode, immediate, var_index, jump_target, func_code,
                    input ready);
    modport sink   (input valid, opcode, immediate, var_index, jump_target, func_code,
                    output ready);
endinterface

interface sbe_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic [2:0]  print_kind;
    logic [31:0] print_value;
    logic        halted;
    logic [1:0]  error_code;
    logic [15:0] executed_count;
    modport source (output valid, next_pc, print_kind, print_value, halted, error_code,
                    executed_count, input ready);
    modport sink   (input valid, next_pc, print_kind, print_value, halted, error_code,
                    executed_count, output ready);
endinterface

/* rtl/sbe_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sbe_pkg for the request and response structs.
module sbe_div
    import sbe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= diff[32] ? rem_sh[31:0] : diff[31:0];
            r_quo <= {r_quo[30:0], ~diff[32]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

/* rtl/sbe_alu.sv */
// Shared arithmetic, logic and compare unit; result is registered by the caller.
// Depends on sbe_pkg for the operation type.
module sbe_alu
    import sbe_pkg::*;
(
    input  t_alu_op     i_op,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic [31:0] o_y
);
    logic [63:0] prod;

    assign prod = i_x * i_y;

    always_comb begin
        unique case (i_op)
            ALU_ADD:  o_y = i_x + i_y;
            ALU_SUB:  o_y = i_x - i_y;
            ALU_MUL:  o_y = prod[31:0];
            ALU_LAND: o_y = {31'd0, (i_x != '0) && (i_y != '0)};
            ALU_LOR:  o_y = {31'd0, (i_x != '0) || (i_y != '0)};
            ALU_LNOT: o_y = {31'd0, i_x == '0};
            ALU_EQ:   o_y = {31'd0, i_x == i_y};
            ALU_NE:   o_y = {31'd0, i_x != i_y};
            ALU_LT:   o_y = {31'd0, i_x < i_y};
            ALU_LE:   o_y = {31'd0, i_x <= i_y};
            ALU_GT:   o_y = {31'd0, i_x > i_y};
            ALU_GE:   o_y = {31'd0, i_x >= i_y};
            ALU_DBL:  o_y = {i_x[30:0], 1'b0};
            default:  o_y = '0;
        endcase
    end
endmodule

/* rtl/stack_bytecode_executor.sv */
// Stack bytecode executor top level: sequencer, stacks, variables, byte buffer.
// Depends on sbe_pkg, sbe_if, sbe_alu and sbe_div.
//
//   channel   dir  handshake      beat
//   i_cmd     in   valid/ready    one pre-decoded instruction
//   o_rsp     out  valid/ready    next pc, print request, halt, error, count
//   i_cfg_*   in   write enable   program_length
//
// One instruction at a time. A plain instruction goes from accept to result through
// accept, variable index fold, two stack reads, execute and write back; NEXT adds
// a compare step. Divide and modulo by a nonzero divisor and string print with a
// nonzero program length also run the shared divider until it is done.
// Buffer access moves one byte per cycle on put; get reads, then captures, each
// byte; the byte address wraps on its low bits, so BUFFER_BYTES must be a power
// of two. Folding the variable index subtracts NUM_VARIABLES until it is in range.
// After reset the byte buffer is cleared, one byte per cycle, with i_cmd held
// not ready. A finished result waits in the output register while the next
// instruction is accepted; write back stalls on it.
module stack_bytecode_executor
    import sbe_pkg::*;
#(
    parameter int STACK_DEPTH   = 32,
    parameter int NUM_VARIABLES = 256,
    parameter int BUFFER_BYTES  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    sbe_cmd_if.sink     i_cmd,
    sbe_rsp_if.source   o_rsp
);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int VIW = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
    localparam int BAW = $clog2(BUFFER_BYTES);
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);
    localparam logic [BAW-1:0] BA_LAST = BAW'(BUFFER_BYTES - 1);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_VMOD  = 11'b00000000100,
        ST_RD1   = 11'b00000001000,
        ST_RD2   = 11'b00000010000,
        ST_EXE   = 11'b00000100000,
        ST_NXT   = 11'b00001000000,
        ST_DIV   = 11'b00010000000,
        ST_BYTE  = 11'b00100000000,
        ST_BCAP  = 11'b01000000000,
        ST_WB    = 11'b10000000000
    } t_state;

    function automatic logic [SPW-1:0] sp_inc(input logic [SPW-1:0] p);
        return (p == SP_LAST) ? '0 : p + SPW'(1);
    endfunction

    function automatic logic [SPW-1:0] sp_dec(input logic [SPW-1:0] p);
        return (p == '0) ? SP_LAST : p - SPW'(1);
    endfunction

    t_state      r_state;
    logic [15:0] r_plen;
    logic [15:0] r_pc;
    logic [15:0] r_cnt;
    logic [SPW-1:0] r_dp;
    logic [SPW-1:0] r_cp;
    logic [BAW-1:0] r_clr;

    // latched instruction
    logic [5:0]  r_op;
    logic [31:0] r_imm;
    logic [7:0]  r_vraw;
    logic [15:0] r_tgt;
    logic [7:0]  r_fn;

    // operands and working values
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_var;
    logic [15:0] r_call;
    logic [31:0] r_res;
    logic        r_dz;
    logic        r_cond;
    logic [BAW-1:0] r_baddr;
    logic [2:0]  r_k;

    // output register
    logic        r_ovld;
    logic [15:0] r_o_pc;
    logic [2:0]  r_o_kind;
    logic [31:0] r_o_val;
    logic        r_o_halt;
    logic [1:0]  r_o_err;
    logic [15:0] r_o_cnt;

    // memories
    logic [31:0] r_ds_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_ds_vld;
    logic [31:0] r_ds_q;
    logic [15:0] r_cs_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_cs_vld;
    logic [15:0] r_cs_q;
    logic [31:0] r_vs_mem [NUM_VARIABLES];
    logic [NUM_VARIABLES-1:0] r_vs_vld;
    logic [31:0] r_vs_q;
    logic [7:0]  r_bf_mem [BUFFER_BYTES];
    logic [7:0]  r_bf_q;

    logic [SPW-1:0] p1, p2, pi, ds_ra, cp_dn, cp_up;
    logic [VIW-1:0] vi;
    logic        ds_we, cs_we, vs_we, bf_we;
    logic [SPW-1:0] ds_wa, cs_wa;
    logic [31:0] ds_wd, vs_wd;
    logic [15:0] cs_wd;
    logic [BAW-1:0] bf_wa;
    logic [7:0]  bf_wd;

    logic        is_bin, is_put, is_get, wb_go, counts;
    logic [2:0]  k_last;
    logic [15:0] n_pc, n_cnt;
    logic [SPW-1:0] n_dp, n_cp;
    logic [2:0]  n_kind;
    logic [31:0] n_val;
    logic        n_halt;
    logic [1:0]  n_err;
    logic [BAW-1:0] baddr_up;

    t_alu_op     alu_op;
    logic [31:0] alu_x, alu_yin, alu_y;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    assign p1    = sp_dec(r_dp);
    assign p2    = sp_dec(p1);
    assign pi    = sp_inc(r_dp);
    assign cp_dn = sp_dec(r_cp);
    assign cp_up = sp_inc(r_cp);
    assign vi    = r_vraw[VIW-1:0];
    assign ds_ra = (r_state == ST_RD2) ? p2 : p1;
    assign baddr_up = (r_baddr == BA_LAST) ? '0 : r_baddr + BAW'(1);

    assign is_bin = (r_op >= OP_ADD) && (r_op <= OP_GE) && (r_op != OP_NOT);
    assign is_put = (r_op == OP_PUT1) || (r_op == OP_PUT2) || (r_op == OP_PUT4);
    assign is_get = (r_op == OP_GET1) || (r_op == OP_GET2) || (r_op == OP_GET4);
    assign wb_go  = (r_state == ST_WB) && (!r_ovld || o_rsp.ready);

    always_comb begin
        priority if (r_op == OP_PUT4 || r_op == OP_GET4) k_last = 3'd3;
        else if (r_op == OP_PUT2 || r_op == OP_GET2)     k_last = 3'd1;
        else                                             k_last = 3'd0;
    end

    // Shared ALU operand select.
    always_comb begin
        alu_op  = ALU_ADD;
        alu_x   = r_ds_q;
        alu_yin = r_b;
        if (r_state == ST_NXT) begin
            alu_op  = ALU_LE;
            alu_x   = r_res;
            alu_yin = r_a;
        end else begin
            unique case (r_op)
                OP_ADD:  alu_op = ALU_ADD;
                OP_SUB:  alu_op = ALU_SUB;
                OP_MUL:  alu_op = ALU_MUL;
                OP_AND:  alu_op = ALU_LAND;
                OP_OR:   alu_op = ALU_LOR;
                OP_EQ:   alu_op = ALU_EQ;
                OP_NE:   alu_op = ALU_NE;
                OP_LT:   alu_op = ALU_LT;
                OP_LE:   alu_op = ALU_LE;
                OP_GT:   alu_op = ALU_GT;
                OP_GE:   alu_op = ALU_GE;
                OP_NOT: begin
                    alu_op = ALU_LNOT;
                    alu_x  = r_b;
                end
                OP_FUNC: begin
                    alu_op = ALU_DBL;
                    alu_x  = r_b;
                end
                OP_NEXT: begin
                    alu_op = ALU_ADD;
                    alu_x  = r_var;
                end
                default: alu_op = ALU_ADD;
            endcase
        end
    end

    sbe_alu u_alu (
        .i_op (alu_op),
        .i_x  (alu_x),
        .i_y  (alu_yin),
        .o_y  (alu_y)
    );

    // Divider requests: quotient/remainder and string address fold.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = r_b;
        div_req.divisor  = {16'd0, r_plen};
        if (r_state == ST_EXE) begin
            if ((r_op == OP_DIV || r_op == OP_MOD) && r_b != '0) begin
                div_req.start    = 1'b1;
                div_req.dividend = r_ds_q;
                div_req.divisor  = r_b;
            end else if (r_op == OP_PRS && r_plen != '0) begin
                div_req.start = 1'b1;
            end
        end
    end

    sbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Write back: stack, call stack and variable writes, next pc and result.
    always_comb begin
        n_pc   = r_pc;
        n_dp   = r_dp;
        n_cp   = r_cp;
        n_kind = PK_NONE;
        n_val  = '0;
        n_halt = 1'b0;
        n_err  = ERR_NONE;
        counts = 1'b1;
        ds_we  = 1'b0;
        ds_wa  = p1;
        ds_wd  = r_res;
        cs_we  = 1'b0;
        cs_wd  = r_pc + 16'd3;
        vs_we  = 1'b0;
        vs_wd  = r_b;
        if (is_bin) begin
            ds_we = 1'b1;
            ds_wa = p2;
            n_dp  = p1;
            n_pc  = r_pc + 16'd1;
            if (r_op == OP_DIV && r_dz) n_err = ERR_DIV0;
        end else begin
            unique case (r_op)
                OP_PRS: begin
                    n_kind = PK_STR;
                    n_val  = r_res;
                    n_dp   = p1;
                    n_pc   = r_pc + 16'd1;
                end
                OP_PRV: begin
                    n_kind = PK_VALUE;
                    n_val  = r_b;
                    n_dp   = p1;
                    n_pc   = r_pc + 16'd1;
                end
                OP_PRNL: begin
                    n_kind = PK_NL;
                    n_pc   = r_pc + 16'd1;
                end
                OP_PRTAB: begin
                    n_kind = PK_TAB;
                    n_pc   = r_pc + 16'd1;
                end
                OP_STR: begin
                    ds_we = 1'b1;
                    ds_wa = r_dp;
                    ds_wd = {16'd0, r_pc + 16'd2};
                    n_dp  = pi;
                    n_pc  = r_pc + {8'd0, r_imm[7:0]} + 16'd2;
                end
                OP_NUM: begin
                    ds_we = 1'b1;
                    ds_wa = r_dp;
                    ds_wd = r_imm;
                    n_dp  = pi;
                    n_pc  = r_pc + 16'd5;
                end
                OP_BNUM: begin
                    ds_we = 1'b1;
                    ds_wa = r_dp;
                    ds_wd = {24'd0, r_imm[7:0]};
                    n_dp  = pi;
                    n_pc  = r_pc + 16'd2;
                end
                OP_LDV: begin
                    ds_we = 1'b1;
                    ds_wa = r_dp;
                    ds_wd = r_var;
                    n_dp  = pi;
                    n_pc  = r_pc + 16'd2;
                end
                OP_STV: begin
                    vs_we = 1'b1;
                    n_dp  = p1;
                    n_pc  = r_pc + 16'd2;
                end
                OP_NOT: begin
                    ds_we = 1'b1;
                    n_pc  = r_pc + 16'd1;
                end
                OP_GOTO: n_pc = r_tgt;
                OP_GOSUB: begin
                    cs_we = 1'b1;
                    n_cp  = cp_up;
                    n_pc  = r_tgt;
                end
                OP_RET: begin
                    n_cp = cp_dn;
                    n_pc = r_call;
                end
                OP_NEXT: begin
                    vs_we = 1'b1;
                    vs_wd = r_res;
                    if (r_cond) begin
                        n_pc = r_tgt;
                    end else begin
                        n_pc = r_pc + 16'd4;
                        n_dp = p2;
                    end
                end
                OP_IF: begin
                    n_dp = p1;
                    n_pc = (r_b == '0) ? r_tgt : r_pc + 16'd3;
                end
                OP_FUNC: begin
                    if (r_fn == FN_PEEK) ds_we = 1'b1;
                    else                 n_err = ERR_FUNC;
                    n_pc = r_pc + 16'd2;
                end
                OP_PUT1, OP_PUT2, OP_PUT4: begin
                    n_dp = p2;
                    n_pc = r_pc + 16'd2;
                end
                OP_GET1, OP_GET2, OP_GET4: begin
                    ds_we = 1'b1;
                    n_pc  = r_pc + 16'd2;
                end
                OP_START: begin
                    n_pc   = START_PC;
                    counts = 1'b0;
                end
                OP_HOSTW: begin
                    vs_we  = 1'b1;
                    vs_wd  = r_imm;
                    counts = 1'b0;
                end
                default: begin
                    n_halt = 1'b1;
                    counts = 1'b0;
                end
            endcase
        end
        if (r_op == OP_START)  n_cnt = '0;
        else if (counts)       n_cnt = r_cnt + 16'd1;
        else                   n_cnt = r_cnt;
        ds_we = ds_we & wb_go;
        cs_we = cs_we & wb_go;
        vs_we = vs_we & wb_go;
    end

    assign cs_wa = r_cp;
    assign bf_we = (r_state == ST_CLEAR) || ((r_state == ST_BYTE) && is_put);
    assign bf_wa = (r_state == ST_CLEAR) ? r_clr : r_baddr;
    assign bf_wd = (r_state == ST_CLEAR) ? 8'd0 : 8'(r_b >> {r_k, 3'b000});

    // Memories: registered reads; entries not yet written read as zero.
    always_ff @(posedge i_clk) begin
        if (ds_we) r_ds_mem[ds_wa] <= ds_wd;
        r_ds_q <= r_ds_vld[ds_ra] ? r_ds_mem[ds_ra] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (cs_we) r_cs_mem[cs_wa] <= cs_wd;
        r_cs_q <= r_cs_vld[cp_dn] ? r_cs_mem[cp_dn] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (vs_we) r_vs_mem[vi] <= vs_wd;
        r_vs_q <= r_vs_vld[vi] ? r_vs_mem[vi] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (bf_we) r_bf_mem[bf_wa] <= bf_wd;
        r_bf_q <= r_bf_mem[r_baddr];
    end

    // Valid bits and architectural control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds_vld <= '0;
            r_cs_vld <= '0;
            r_vs_vld <= '0;
            r_state  <= ST_CLEAR;
            r_plen   <= PLEN_RST;
            r_pc     <= '0;
            r_cnt    <= '0;
            r_dp     <= '0;
            r_cp     <= '0;
            r_clr    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (ds_we) r_ds_vld[ds_wa] <= 1'b1;
            if (cs_we) r_cs_vld[cs_wa] <= 1'b1;
            if (vs_we) r_vs_vld[vi]    <= 1'b1;
            if (i_cfg_we) r_plen <= i_cfg_wdata;
            // load a new result, or drop the held one once taken
            if (wb_go)             r_ovld <= 1'b1;
            else if (o_rsp.ready)  r_ovld <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + BAW'(1);
                    if (r_clr == BA_LAST) r_state <= ST_IDLE;
                end
                ST_IDLE:  if (i_cmd.valid) r_state <= ST_VMOD;
                ST_VMOD:  if ({1'b0, r_vraw} < 9'(NUM_VARIABLES)) r_state <= ST_RD1;
                ST_RD1:   r_state <= ST_RD2;
                ST_RD2:   r_state <= ST_EXE;
                ST_EXE: begin
                    priority if ((r_op == OP_DIV || r_op == OP_MOD) && r_b != '0)
                        r_state <= ST_DIV;
                    else if (r_op == OP_PRS && r_plen != '0) r_state <= ST_DIV;
                    else if (is_put || is_get)               r_state <= ST_BYTE;
                    else if (r_op == OP_NEXT)                r_state <= ST_NXT;
                    else                                     r_state <= ST_WB;
                end
                ST_NXT:   r_state <= ST_WB;
                ST_DIV:   if (div_rsp.done) r_state <= ST_WB;
                ST_BYTE: begin
                    if (!is_put)            r_state <= ST_BCAP;
                    else if (r_k == k_last) r_state <= ST_WB;
                end
                ST_BCAP:  r_state <= (r_k == k_last) ? ST_WB : ST_BYTE;
                ST_WB: begin
                    if (wb_go) begin
                        r_pc    <= n_pc;
                        r_cnt   <= n_cnt;
                        r_dp    <= n_dp;
                        r_cp    <= n_cp;
                        r_state <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_op   <= i_cmd.opcode;
                r_imm  <= i_cmd.immediate;
                r_vraw <= i_cmd.var_index;
                r_tgt  <= i_cmd.jump_target;
                r_fn   <= i_cmd.func_code;
            end
            ST_VMOD: begin
                // fold the variable number into range
                if ({1'b0, r_vraw} >= 9'(NUM_VARIABLES))
                    r_vraw <= r_vraw - 8'(NUM_VARIABLES);
            end
            ST_RD2: begin
                r_b    <= r_ds_q;
                r_var  <= r_vs_q;
                r_call <= r_cs_q;
            end
            ST_EXE: begin
                r_a  <= r_ds_q;
                r_dz <= (r_b == '0);
                // byte address: variable base plus offset, wrapping on the low bits
                r_baddr <= r_var[BAW-1:0] + (is_put ? r_ds_q[BAW-1:0] : r_b[BAW-1:0]);
                r_k     <= '0;
                if ((r_op == OP_DIV || r_op == OP_MOD) && r_b == '0) r_res <= '0;
                else if (r_op == OP_PRS)                             r_res <= r_b;
                else if (is_get)                                     r_res <= '0;
                else                                                 r_res <= alu_y;
            end
            ST_NXT:   r_cond <= alu_y[0];
            ST_DIV: begin
                if (div_rsp.done)
                    r_res <= (r_op == OP_DIV) ? div_rsp.quot : div_rsp.rem;
            end
            ST_BYTE: begin
                if (is_put) begin
                    r_k     <= r_k + 3'd1;
                    r_baddr <= baddr_up;
                end
            end
            ST_BCAP: begin
                r_res   <= r_res | ({24'd0, r_bf_q} << {r_k, 3'b000});
                r_k     <= r_k + 3'd1;
                r_baddr <= baddr_up;
            end
            ST_WB: begin
                if (wb_go) begin
                    r_o_pc   <= n_pc;
                    r_o_kind <= n_kind;
                    r_o_val  <= n_val;
                    r_o_halt <= n_halt;
                    r_o_err  <= n_err;
                    r_o_cnt  <= n_cnt;
                end
            end
            default: ;
        endcase
    end

    assign i_cmd.ready          = (r_state == ST_IDLE);
    assign o_rsp.valid          = r_ovld;
    assign o_rsp.next_pc        = r_o_pc;
    assign o_rsp.print_kind     = r_o_kind;
    assign o_rsp.print_value    = r_o_val;
    assign o_rsp.halted         = r_o_halt;
    assign o_rsp.error_code     = r_o_err;
    assign o_rsp.executed_count = r_o_cnt;
endmodule
